FILE: rtl/text_scope_grid_renderer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text scope grid renderer
// Same-cycle and next-cycle implication checks, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef TEXT_SCOPE_GRID_RENDERER_ASSERT_SVH
`define TEXT_SCOPE_GRID_RENDERER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSGR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tsgr_pkg.sv
// ---------------------------------------------------------------------------
// tsgr_pkg
// Shared types and constants of the text scope grid renderer.
// ---------------------------------------------------------------------------
package tsgr_pkg;

  typedef enum logic [0:0] {
    FUNC_STORE  = 1'b0,
    FUNC_RENDER = 1'b1
  } func_t;

  // Column store write request
  typedef struct packed {
    logic       en;
    logic [6:0] addr;
    logic [5:0] level;
  } wr_req_t;

  localparam logic [5:0]  LEVEL_TOP = 6'd40;
  localparam logic [12:0] SCALE_DIV = 13'd4095;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TRACE_LO = 8'hdc;
  localparam logic [7:0] CH_TRACE_HI = 8'hdf;
  localparam logic [7:0] CH_CROSS    = 8'hc5;
  localparam logic [7:0] CH_HBAR     = 8'hc4;
  localparam logic [7:0] CH_VBAR     = 8'hb3;
  localparam logic [7:0] CH_TOP_L    = 8'hda;
  localparam logic [7:0] CH_TOP_R    = 8'hbf;
  localparam logic [7:0] CH_TOP_T    = 8'hc2;
  localparam logic [7:0] CH_BOT_L    = 8'hc0;
  localparam logic [7:0] CH_BOT_R    = 8'hd9;
  localparam logic [7:0] CH_BOT_T    = 8'hc1;
  localparam logic [7:0] CH_MID_L    = 8'hc3;
  localparam logic [7:0] CH_MID_R    = 8'hb4;

endpackage

FILE: rtl/tsgr_cmd_if.sv
// ---------------------------------------------------------------------------
// tsgr_cmd_if
// Request channel: store a sample or render one character cell.
// ---------------------------------------------------------------------------
interface tsgr_cmd_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [6:0]  column;
  logic [4:0]  row;
  logic [11:0] sample;

  modport source (output valid, func, column, row, sample, input ready);
  modport sink   (input valid, func, column, row, sample, output ready);
endinterface

FILE: rtl/tsgr_cell_if.sv
// ---------------------------------------------------------------------------
// tsgr_cell_if
// Result channel: one rendered character cell.
// ---------------------------------------------------------------------------
interface tsgr_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_trace;

  modport source (output valid, char_code, is_trace, input ready);
  modport sink   (input valid, char_code, is_trace, output ready);
endinterface

FILE: rtl/tsgr_scale.sv
// ---------------------------------------------------------------------------
// tsgr_scale
// Sample to half-row level: 40 - floor(sample * 40 / 4095).
// ---------------------------------------------------------------------------
module tsgr_scale (
  input  logic [11:0] sample,
  output logic [5:0]  level
);
  import tsgr_pkg::*;

  logic [17:0] scaled;
  logic [5:0]  q_est;
  logic [12:0] rem;
  logic [5:0]  quot;

  // x / 4095 ~ x / 4096; remainder stays below 2 * 4095, so one correction
  always_comb begin
    scaled = 18'({sample, 5'b0}) + 18'({sample, 3'b0});
    q_est  = scaled[17:12];
    rem    = {1'b0, scaled[11:0]} + 13'(q_est);
    quot   = q_est + ((rem >= SCALE_DIV) ? 6'd1 : 6'd0);
    level  = LEVEL_TOP - quot;
  end
endmodule

FILE: rtl/tsgr_colmem.sv
// ---------------------------------------------------------------------------
// tsgr_colmem
// Column level store: one read, one write port, valid bits, write forward.
// ---------------------------------------------------------------------------
module tsgr_colmem #(
  parameter int COLUMNS = 101
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [6:0]        rd_addr,
  input  tsgr_pkg::wr_req_t wr,
  output logic [5:0]        rd_level
);
  import tsgr_pkg::*;

  localparam int AW = $clog2(COLUMNS);

  logic [5:0]         mem [COLUMNS];
  logic [COLUMNS-1:0] vld;
  logic [5:0]         rd_data;
  logic               rd_vld;
  logic [6:0]         rd_col;
  wr_req_t            fw;
  logic [AW-1:0]      ra;
  logic               ra_ok;

  always_comb begin
    ra_ok = {1'b0, rd_addr} < 8'(COLUMNS);
    ra    = ra_ok ? rd_addr[AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[ra];
      rd_col  <= rd_addr;
    end
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
      fw     <= '0;
    end else begin
      if (rd_en) begin
        rd_vld <= vld[ra];
      end
      if (wr.en) begin
        vld[wr.addr[AW-1:0]] <= 1'b1;
        fw                   <= wr;
      end
    end
  end

  // latest write wins over a read issued on the same edge
  always_comb begin
    if (fw.en && (fw.addr == rd_col)) begin
      rd_level = fw.level;
    end else if (rd_vld) begin
      rd_level = rd_data;
    end else begin
      rd_level = '0;
    end
  end
endmodule

FILE: rtl/tsgr_cell.sv
// ---------------------------------------------------------------------------
// tsgr_cell
// Glyph select for one cell: grid box drawing or trace mark.
// ---------------------------------------------------------------------------
module tsgr_cell #(
  parameter int COLUMNS = 101,
  parameter int ROWS    = 21
) (
  input  logic [6:0] column,
  input  logic [4:0] row,
  input  logic [5:0] level,
  output logic [7:0] char_code,
  output logic       is_trace
);
  import tsgr_pkg::*;

  localparam logic [6:0] ColLast = 7'(COLUMNS - 1);
  localparam logic [6:0] RowLast = 7'(ROWS - 1);

  logic [14:0] prod;
  logic [3:0]  q10;
  logic [6:0]  r10;
  logic        on_screen, hline, vline, left, right;
  logic [7:0]  grid;

  always_comb begin
    // column / 10 by reciprocal, exact below 1029
    prod  = 15'(column) * 15'd205;
    q10   = prod[14:11];
    r10   = column - (7'({q10, 3'b0}) + 7'({q10, 1'b0}));
    vline = r10 == 7'd0;
    hline = row[1:0] == 2'b00;
    left  = column == 7'd0;
    right = column == ColLast;

    on_screen = ({1'b0, column} < 8'(COLUMNS)) && ({2'b0, row} < 7'(ROWS));

    if (!hline) begin
      grid = vline ? CH_VBAR : CH_SPACE;
    end else if (!vline) begin
      grid = CH_HBAR;
    end else if (row == 5'd0) begin
      grid = left ? CH_TOP_L : (right ? CH_TOP_R : CH_TOP_T);
    end else if ({2'b0, row} == RowLast) begin
      grid = left ? CH_BOT_L : (right ? CH_BOT_R : CH_BOT_T);
    end else begin
      grid = left ? CH_MID_L : (right ? CH_MID_R : CH_CROSS);
    end

    if (!on_screen) begin
      char_code = CH_SPACE;
      is_trace  = 1'b0;
    end else if (level[5:1] == row) begin
      char_code = level[0] ? CH_TRACE_LO : CH_TRACE_HI;
      is_trace  = 1'b1;
    end else begin
      char_code = grid;
      is_trace  = 1'b0;
    end
  end
endmodule

FILE: rtl/text_scope_grid_renderer.sv
// A render passes the stage one register, then the output register once that is free.
// Throughput: one request per cycle, store or render, while renders are not stalled; set
// by the single store read port (read at accept) and write port (store leaving stage one).
// Reset (rst, synchronous): clears pipeline valids and the store's per-column valid bits,
// so every column reads level zero; no clearing pass, ready right after.
// ---------------------------------------------------------------------------
// text_scope_grid_renderer
// Character-cell scope renderer: per-column level store plus CP437 grid
// and trace glyph generation, one cell per clock while the output is not stalled.
// ---------------------------------------------------------------------------
`include "text_scope_grid_renderer_assert.svh"

module text_scope_grid_renderer #(
  parameter int COLUMNS = 101,
  parameter int ROWS    = 21
) (
  input  logic         clk,
  input  logic         rst,
  tsgr_cmd_if.sink     cmd,
  tsgr_cell_if.source  glyph
);
  import tsgr_pkg::*;

  // Stage one: request register; the store read issued at accept lands here
  logic        s1_valid;
  func_t       s1_func;
  logic [6:0]  s1_column;
  logic [4:0]  s1_row;
  logic [11:0] s1_sample;

  // Output register, parts the two handshakes
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_trace;

  logic        accept, s1_adv, out_load, s1_col_ok;
  logic [5:0]  s1_new_level, s1_cur_level;
  logic [7:0]  cell_char;
  logic        cell_trace;
  wr_req_t     wr;

  // Stores leave stage one unconditionally; renders need a free output slot
  always_comb begin
    s1_adv    = s1_valid && ((s1_func == FUNC_STORE) || !out_valid || glyph.ready);
    cmd.ready = !s1_valid || s1_adv;
    accept    = cmd.valid && cmd.ready;
    out_load  = s1_adv && (s1_func == FUNC_RENDER);
    s1_col_ok = {1'b0, s1_column} < 8'(COLUMNS);

    wr.en    = s1_adv && (s1_func == FUNC_STORE) && s1_col_ok;
    wr.addr  = s1_column;
    wr.level = s1_new_level;
  end

  tsgr_scale u_scale (
    .sample (s1_sample),
    .level  (s1_new_level)
  );

  // Read at accept; a write on that same edge is forwarded inside the store
  tsgr_colmem #(.COLUMNS(COLUMNS)) u_colmem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (cmd.column),
    .wr       (wr),
    .rd_level (s1_cur_level)
  );

  tsgr_cell #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_cell (
    .column    (s1_column),
    .row       (s1_row),
    .level     (s1_cur_level),
    .char_code (cell_char),
    .is_trace  (cell_trace)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (glyph.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func   <= func_t'(cmd.func);
      s1_column <= cmd.column;
      s1_row    <= cmd.row;
      s1_sample <= cmd.sample;
    end
    if (out_load) begin
      out_char  <= cell_char;
      out_trace <= cell_trace;
    end
  end

  assign glyph.valid     = out_valid;
  assign glyph.char_code = out_char;
  assign glyph.is_trace  = out_trace;

  // A trace flag always comes with one of the two trace glyphs
  `TSGR_ASSERT_NOW(a_trace_glyph, clk, rst, out_valid && out_trace, (out_char == CH_TRACE_LO) || (out_char == CH_TRACE_HI), "trace flag without trace glyph")
  // A stalled output slot is never overwritten
  `TSGR_ASSERT_NOW(a_no_overwrite, clk, rst, out_load, !out_valid || glyph.ready, "result overwritten while stalled")
  // Store requests never hold up stage one
  `TSGR_ASSERT_NOW(a_store_flows, clk, rst, s1_valid && (s1_func == FUNC_STORE), s1_adv && cmd.ready, "store request stalled")
  // A render leaving stage one is on the output next cycle
  `TSGR_ASSERT_NEXT(a_render_lands, clk, rst, out_load, out_valid, "render result lost")

endmodule

FILE: tb/text_scope_grid_renderer_test.sv
// ---------------------------------------------------------------------------
// text_scope_grid_renderer_test
// Self-checking bench for the character-cell scope renderer. A short table of
// directed requests covers grid corners, tees, bars, trace glyphs and
// off-screen cells. Random store and render requests follow, with many
// renders aimed at the trace row. Every cell is checked against a hand-typed
// expectation or a bench-side model of the column store and the glyph rules.
// ---------------------------------------------------------------------------
module text_scope_grid_renderer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsgr_pkg::*;

  localparam int COLUMNS      = 101;
  localparam int ROWS         = 21;
  localparam int RANDOM_ITEMS = 1825;
  localparam int HOLD_CYCLES  = 250;  // long output stall
  localparam int HOLD_AT      = 400;  // requests accepted before the stall
  localparam int DRAIN_AT     = 1000; // sender waits for all cells here
  localparam int QUIET_FROM   = 1200; // no idling on either side ...
  localparam int QUIET_TO     = 1500; // ... up to here
  localparam int IDLE_PCT     = 21;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_trace;
  } cell_t;

  // One request, plus an optional hand-typed cell to expect.
  typedef struct packed {
    func_t       func;
    logic [6:0]  column;
    logic [4:0]  row;
    logic [11:0] sample;
    logic        typed;
    logic [7:0]  want_char;
    logic        want_trace;
  } probe_t;

  logic clk = 1'b0;
  logic rst;

  tsgr_cmd_if  cmd ();
  tsgr_cell_if glyph ();

  text_scope_grid_renderer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .glyph(glyph)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the column store, updated as store requests are accepted.
  logic [5:0] level_mem [COLUMNS];
  cell_t      cells_due [$];
  int         errors;
  int         sent_count;
  logic       quiet;

  // Hand-typed expectation travelling with the request on the bus.
  logic       cmd_typed;
  cell_t      cmd_want;

  // Directed requests. Column store is all zero after reset, so every column
  // starts with the even trace glyph on row 0.
  probe_t probe_tab [26] = '{
    // func         col      row     sample    typed  char         trace
    '{FUNC_RENDER, 7'd0,   5'd0,  12'd0,    1'b1, CH_TRACE_HI, 1'b1},
    '{FUNC_RENDER, 7'd100, 5'd0,  12'd0,    1'b1, CH_TRACE_HI, 1'b1},
    '{FUNC_RENDER, 7'd100, 5'd20, 12'd0,    1'b1, CH_BOT_R,    1'b0},
    '{FUNC_RENDER, 7'd0,   5'd20, 12'd0,    1'b1, CH_BOT_L,    1'b0},
    '{FUNC_RENDER, 7'd0,   5'd4,  12'd0,    1'b1, CH_MID_L,    1'b0},
    '{FUNC_RENDER, 7'd50,  5'd4,  12'd0,    1'b1, CH_CROSS,    1'b0},
    '{FUNC_RENDER, 7'd100, 5'd4,  12'd0,    1'b1, CH_MID_R,    1'b0},
    '{FUNC_RENDER, 7'd5,   5'd8,  12'd0,    1'b1, CH_HBAR,     1'b0},
    '{FUNC_RENDER, 7'd10,  5'd1,  12'd0,    1'b1, CH_VBAR,     1'b0},
    '{FUNC_RENDER, 7'd5,   5'd1,  12'd0,    1'b1, CH_SPACE,    1'b0},
    '{FUNC_RENDER, 7'd50,  5'd20, 12'd0,    1'b1, CH_BOT_T,    1'b0},
    // lowest sample gives the top level, moving the trace to the bottom row
    '{FUNC_STORE,  7'd0,   5'd0,  12'd0,    1'b0, 8'h00,       1'b0},
    '{FUNC_STORE,  7'd50,  5'd0,  12'd0,    1'b0, 8'h00,       1'b0},
    '{FUNC_STORE,  7'd100, 5'd0,  12'd0,    1'b0, 8'h00,       1'b0},
    '{FUNC_RENDER, 7'd0,   5'd0,  12'd0,    1'b1, CH_TOP_L,    1'b0},
    '{FUNC_RENDER, 7'd50,  5'd0,  12'd0,    1'b1, CH_TOP_T,    1'b0},
    '{FUNC_RENDER, 7'd100, 5'd0,  12'd0,    1'b1, CH_TOP_R,    1'b0},
    '{FUNC_RENDER, 7'd50,  5'd20, 12'd0,    1'b1, CH_TRACE_HI, 1'b1},
    // off-screen cells read as blanks
    '{FUNC_RENDER, 7'd127, 5'd31, 12'hfff,  1'b1, CH_SPACE,    1'b0},
    '{FUNC_RENDER, 7'd3,   5'd21, 12'd0,    1'b1, CH_SPACE,    1'b0},
    // store beyond the last column is dropped
    '{FUNC_STORE,  7'd127, 5'd31, 12'hfff,  1'b0, 8'h00,       1'b0},
    '{FUNC_RENDER, 7'd127, 5'd0,  12'd0,    1'b1, CH_SPACE,    1'b0},
    // odd level: lower half-block glyph
    '{FUNC_STORE,  7'd7,   5'd0,  12'd103,  1'b0, 8'h00,       1'b0},
    '{FUNC_RENDER, 7'd7,   5'd19, 12'd0,    1'b0, 8'h00,       1'b0},
    // mid-scale sample puts the trace half-way down
    '{FUNC_STORE,  7'd9,   5'd0,  12'd2048, 1'b0, 8'h00,       1'b0},
    '{FUNC_RENDER, 7'd9,   5'd10, 12'hfff,  1'b0, 8'h00,       1'b0}
  };

  // level = 40 - floor(sample * 40 / 4095)
  function automatic logic [5:0] scale_level(logic [11:0] sample);
    int unsigned prod;
    prod = sample;
    prod = prod * 40;
    return 6'(40 - prod / 4095);
  endfunction

  function automatic cell_t draw_cell(logic [6:0] col, logic [4:0] row);
    cell_t      c;
    logic [5:0] lvl;
    logic       hline, vline, left_edge, right_edge;
    c.is_trace  = 1'b0;
    c.char_code = CH_SPACE;
    if (col >= COLUMNS || row >= ROWS) begin
      return c;
    end
    lvl = level_mem[col];
    if ((lvl >> 1) == 6'(row)) begin
      c.is_trace  = 1'b1;
      c.char_code = lvl[0] ? CH_TRACE_LO : CH_TRACE_HI;
      return c;
    end
    hline      = (row[1:0] == 2'd0);
    vline      = ((col % 10) == 0);
    left_edge  = (col == 0);
    right_edge = (col == COLUMNS - 1);
    if (hline && !vline) begin
      c.char_code = CH_HBAR;
    end else if (hline && row == 0) begin
      c.char_code = left_edge ? CH_TOP_L : (right_edge ? CH_TOP_R : CH_TOP_T);
    end else if (hline && row == ROWS - 1) begin
      c.char_code = left_edge ? CH_BOT_L : (right_edge ? CH_BOT_R : CH_BOT_T);
    end else if (hline) begin
      c.char_code = left_edge ? CH_MID_L : (right_edge ? CH_MID_R : CH_CROSS);
    end else if (vline) begin
      c.char_code = CH_VBAR;
    end
    return c;
  endfunction

  // Random request. Columns and rows now and then fall off the screen, and a
  // good share of renders aim at the row the trace sits on.
  function automatic probe_t random_probe();
    probe_t p;
    int     pick;
    p          = '0;
    p.sample   = 12'($urandom);
    p.row      = 5'($urandom);
    pick       = $urandom_range(99);
    p.column   = ($urandom_range(99) < 8) ? 7'($urandom_range(127, COLUMNS))
                                          : 7'($urandom_range(COLUMNS - 1));
    if (pick < 35) begin
      p.func = FUNC_STORE;
      case ($urandom_range(9))
        0: p.sample = 12'd0;
        1: p.sample = 12'hfff;
        default: ;
      endcase
    end else begin
      p.func = FUNC_RENDER;
      pick   = $urandom_range(99);
      if (pick < 35 && p.column < COLUMNS) begin
        p.row = 5'(level_mem[p.column] >> 1);
      end else if (pick < 43) begin
        p.row = 5'($urandom_range(31, ROWS));
      end else begin
        p.row = 5'($urandom_range(ROWS - 1));
      end
    end
    return p;
  endfunction

  // Present one request from the falling edge and hold it until accepted.
  task automatic offer(input probe_t p);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid  <= 1'b1;
    cmd.func   <= p.func;
    cmd.column <= p.column;
    cmd.row    <= p.row;
    cmd.sample <= p.sample;
    cmd_typed  <= p.typed;
    cmd_want   <= '{p.want_char, p.want_trace};
    do @(posedge clk); while (!cmd.ready);
    sent_count++;
    @(negedge clk);
  endtask

  // Lower valid and wait for every outstanding cell.
  task automatic drain_cells();
    cmd.valid <= 1'b0;
    do @(negedge clk); while (cells_due.size() != 0);
  endtask

  // Request side: predict on acceptance. Values read here are the ones that
  // held just before the edge.
  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready) begin
      if (cmd.func == FUNC_STORE) begin
        if (cmd.column < COLUMNS) begin
          level_mem[cmd.column] = scale_level(cmd.sample);
        end
      end else begin
        cells_due.push_back(cmd_typed ? cmd_want : draw_cell(cmd.column, cmd.row));
      end
    end
  end

  // Cell side: compare each accepted cell with the oldest one due.
  always @(posedge clk) begin
    cell_t want;
    if (!rst && glyph.valid && glyph.ready) begin
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected cell, expected none, got char %h trace %b",
                 $time, glyph.char_code, glyph.is_trace);
        errors++;
      end else begin
        want = cells_due.pop_front();
        if (glyph.char_code !== want.char_code) begin
          $display("%0t: char_code mismatch, expected %h, got %h",
                   $time, want.char_code, glyph.char_code);
          errors++;
        end
        if (glyph.is_trace !== want.is_trace) begin
          $display("%0t: is_trace mismatch, expected %b, got %b",
                   $time, want.is_trace, glyph.is_trace);
          errors++;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off once enough requests
  // have gone in, and none at all while the quiet window lasts.
  initial begin
    int unsigned hold_left;
    logic        hold_done;
    logic        rdy;
    hold_left   = 0;
    hold_done   = 1'b0;
    glyph.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        rdy = 1'b0;
        hold_left--;
      end else if (quiet) begin
        rdy = 1'b1;
      end else begin
        rdy = ($urandom_range(99) >= IDLE_PCT);
      end
      glyph.ready <= rdy;
    end
  end

  initial begin
    probe_t p;
    int     counted;
    logic   drained;
    foreach (level_mem[i]) level_mem[i] = '0;
    errors     = 0;
    sent_count = 0;
    quiet      = 1'b0;
    rst        = 1'b1;
    cmd.valid  = 1'b0;
    cmd.func   = FUNC_STORE;
    cmd.column = '0;
    cmd.row    = '0;
    cmd.sample = '0;
    cmd_typed  = 1'b0;
    cmd_want   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (probe_tab[i]) offer(probe_tab[i]);

    // Dropped stores (column past the edge) do not count towards the total.
    counted = 0;
    drained = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      p = random_probe();
      if (!(p.func == FUNC_STORE && p.column >= COLUMNS)) counted++;
      quiet = (counted >= QUIET_FROM && counted < QUIET_TO);
      if (!drained && counted >= DRAIN_AT) begin
        drain_cells();
        drained = 1'b1;
      end
      offer(p);
    end

    drain_cells();
    repeat (10) @(negedge clk);  // catch any stray cell
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
